// ----- src/pus_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_pkg
// Shared types and constants of the pixel undo stack.
// ----------------------------------------------------------------------------
package pus_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	localparam int OFFSET_W = 20;
	localparam int PIX_W    = 3;
	localparam int COLOR_W  = 2;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [PIX_W-1:0]    x;
		logic [PIX_W-1:0]    y;
		logic [COLOR_W-1:0]  color;
		logic                paste;
	} edit_rec_t;

	localparam int REC_W = $bits(edit_rec_t);

	// controller to datapath
	typedef struct packed {
		logic latch;   // capture the incoming item
		logic wrap;    // drop top pointer to zero
		logic rd_top;  // read entry below top
		logic dec;     // top pointer minus one
		logic wr;      // store item at top, top pointer plus one
	} pus_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic top_zero;
		logic top_full;
		logic same_pixel;
		logic more;
	} pus_sts_t;

endpackage

// ----- src/pus_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_in_if
// Request channel of the pixel undo stack: push or pop items.
// ----------------------------------------------------------------------------
interface pus_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [19:0] tile_offset;
	logic [2:0]  pixel_x;
	logic [2:0]  pixel_y;
	logic [1:0]  old_color;
	logic        is_paste;

	modport source (
		output valid, func, tile_offset, pixel_x, pixel_y, old_color, is_paste,
		input  ready
	);
	modport sink (
		input  valid, func, tile_offset, pixel_x, pixel_y, old_color, is_paste,
		output ready
	);
endinterface

// ----- src/pus_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_out_if
// Restore channel of the pixel undo stack.
// ----------------------------------------------------------------------------
interface pus_out_if;
	logic        valid;
	logic        ready;
	logic [19:0] restore_offset;
	logic [2:0]  restore_x;
	logic [2:0]  restore_y;
	logic [1:0]  restore_color;
	logic        last_restore;

	modport source (
		output valid, restore_offset, restore_x, restore_y, restore_color, last_restore,
		input  ready
	);
	modport sink (
		input  valid, restore_offset, restore_x, restore_y, restore_color, last_restore,
		output ready
	);
endinterface

// ----- src/pus_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pus_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/pus_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_ctrl
// Sequencer of the pixel undo stack: push check and chained pop walk.
// ----------------------------------------------------------------------------
module pus_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_func,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pus_pkg::pus_sts_t sts,
	output pus_pkg::pus_cmd_t cmd
);
	import pus_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_PUSH_RD  = 3'd1;
	localparam logic [2:0] ST_PUSH_CMP = 3'd2;
	localparam logic [2:0] ST_POP_RD   = 3'd3;
	localparam logic [2:0] ST_POP_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       in_xfer;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_POP_OUT);
	assign in_xfer   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					cmd.latch = 1'b1;
					if (in_func == FUNC_PUSH) begin
						cmd.wrap = sts.top_full;
						state_d  = ST_PUSH_RD;
					end else if (!sts.top_zero) begin
						state_d = ST_POP_RD;
					end
				end
			end
			ST_PUSH_RD: begin
				// empty stack: nothing to compare against
				if (sts.top_zero) begin
					cmd.wr  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.rd_top = 1'b1;
					state_d    = ST_PUSH_CMP;
				end
			end
			ST_PUSH_CMP: begin
				cmd.wr  = !sts.same_pixel;
				state_d = ST_IDLE;
			end
			ST_POP_RD: begin
				cmd.rd_top = 1'b1;
				cmd.dec    = 1'b1;
				state_d    = ST_POP_OUT;
			end
			ST_POP_OUT: begin
				if (out_ready) begin
					state_d = sts.more ? ST_POP_RD : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/pus_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_dp
// Datapath of the pixel undo stack: top pointer, item register, record RAM.
// ----------------------------------------------------------------------------
module pus_dp #(
	parameter int STACK_DEPTH = pus_pkg::STACK_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pus_pkg::pus_cmd_t            cmd,
	output pus_pkg::pus_sts_t            sts,
	input  logic [pus_pkg::OFFSET_W-1:0] tile_offset,
	input  logic [pus_pkg::PIX_W-1:0]    pixel_x,
	input  logic [pus_pkg::PIX_W-1:0]    pixel_y,
	input  logic [pus_pkg::COLOR_W-1:0]  old_color,
	input  logic                         is_paste,
	output pus_pkg::edit_rec_t           rd_rec
);
	import pus_pkg::*;

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(STACK_DEPTH);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

	logic [PTR_W-1:0]  top_q;
	logic [PTR_W-1:0]  top_m1;
	edit_rec_t         item_q;
	logic [REC_W-1:0]  rdata;

	assign top_m1 = top_q - PTR_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.wrap) begin
			top_q <= '0;
		end else if (cmd.dec) begin
			top_q <= top_m1;
		end else if (cmd.wr) begin
			top_q <= top_q + PTR_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q.offset <= tile_offset;
			item_q.x      <= pixel_x;
			item_q.y      <= pixel_y;
			item_q.color  <= old_color;
			item_q.paste  <= is_paste;
		end
	end

	pus_ram #(
		.WIDTH  (REC_W),
		.DEPTH  (STACK_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (top_q[ADDR_W-1:0]),
		.wdata (item_q),
		.re    (cmd.rd_top),
		.raddr (top_m1[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign rd_rec = edit_rec_t'(rdata);

	assign sts.top_zero   = (top_q == '0);
	assign sts.top_full   = (top_q == PTR_FULL);
	assign sts.same_pixel = (rd_rec.offset == item_q.offset) && (rd_rec.x == item_q.x)
		&& (rd_rec.y == item_q.y);
	// top pointer is already past the popped entry here
	assign sts.more       = rd_rec.paste && (top_q != '0);

endmodule

// ----- src/pixel_undo_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_undo_stack
// Bounded undo stack of pixel edits with chained paste restore.
// ----------------------------------------------------------------------------
// A push on an empty stack just writes the edit; otherwise the entry
// below the top is read from the record RAM (registered read) and compared
// with the new edit before the write. A pop is accepted, then each restore
// is a RAM read followed by the restore being offered until it transfers;
// a chained pop walks on while the restored entry is a paste and the stack
// is not empty. New requests are taken only once the previous one has
// finished; a pop on an empty stack gives no restore and a duplicate push
// stores nothing. The record RAM needs no clearing after reset.
module pixel_undo_stack #(
	parameter int STACK_DEPTH = pus_pkg::STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pus_in_if.sink    in_ch,
	pus_out_if.source out_ch
);
	import pus_pkg::*;

	pus_cmd_t  cmd;
	pus_sts_t  sts;
	edit_rec_t rd_rec;

	pus_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_func   (in_ch.func),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pus_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.tile_offset (in_ch.tile_offset),
		.pixel_x     (in_ch.pixel_x),
		.pixel_y     (in_ch.pixel_y),
		.old_color   (in_ch.old_color),
		.is_paste    (in_ch.is_paste),
		.rd_rec      (rd_rec)
	);

	assign out_ch.restore_offset = rd_rec.offset;
	assign out_ch.restore_x      = rd_rec.x;
	assign out_ch.restore_y      = rd_rec.y;
	assign out_ch.restore_color  = rd_rec.color;
	assign out_ch.last_restore   = !sts.more;

endmodule
